>>> hw/rtl/dns_query_builder_macros.svh
// Assertion macros used by the top-level RTL file of the query builder.
`ifndef DNS_QUERY_BUILDER_MACROS_SVH
`define DNS_QUERY_BUILDER_MACROS_SVH

`ifndef SYNTHESIS
`define DQB_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dqb assertion failed");
`define DQB_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dqb assertion failed");
`else
`define DQB_ASSERT_SAME(name, clk, rstn, ante, cons)
`define DQB_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/dqb_pkg.sv
package dqb_pkg;

    localparam int MAX_LABEL_DEF = 32;
    localparam int SEQ_W = 4;
    localparam int HEADER_LEN = 12;
    localparam int TAIL_LEN = 5;

    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [7:0] BYTE_ONE = 8'h01;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    localparam logic [SEQ_W-1:0] HDR_ID_HI = SEQ_W'(0);
    localparam logic [SEQ_W-1:0] HDR_ID_LO = SEQ_W'(1);
    localparam logic [SEQ_W-1:0] HDR_FLAGS_HI = SEQ_W'(2);
    localparam logic [SEQ_W-1:0] HDR_QDCOUNT_LO = SEQ_W'(5);
    localparam logic [SEQ_W-1:0] HDR_LAST = SEQ_W'(HEADER_LEN - 1);
    localparam logic [SEQ_W-1:0] TAIL_TYPE_LO = SEQ_W'(2);
    localparam logic [SEQ_W-1:0] TAIL_LAST = SEQ_W'(TAIL_LEN - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEADER,
        ST_LEN,
        ST_DATA,
        ST_TAIL
    } state_t;

    typedef enum logic [1:0] {
        SEL_HEADER,
        SEL_LEN,
        SEL_DATA,
        SEL_TAIL
    } byte_sel_t;

    typedef struct packed {
        logic      accept;
        logic      emit;
        byte_sel_t sel;
        logic      out_last;
        logic      seq_inc;
        logic      seq_clr;
        logic      rd_start;
        logic      rd_step;
        logic      clear_count;
    } cmd_t;

    typedef struct packed {
        logic             in_message;
        logic             in_dot;
        logic             in_last;
        logic             held_dot;
        logic             held_last;
        logic             count_zero;
        logic             rd_done;
        logic             out_free;
        logic [SEQ_W-1:0] seq;
    } status_t;

endpackage

>>> hw/rtl/dns_query_builder.sv
// Channel | Direction | Handshake                | Contents
// s_      | in        | s_tvalid / s_tready      | one name character per request
// m_      | out       | m_tvalid / m_tready      | one query message byte per request
//
// Every request is taken while the sequencer is idle. A request that opens a name then
// holds s_tready low while the 12 header bytes go out; a dot or the last character adds
// the length byte and L label bytes, read one per cycle from the label buffer unless m_
// stalls, and the last character adds the 5 tail bytes. Other characters need no more.
// Reset is synchronous and active low; the label buffer is not cleared.
// A stalled m_ channel holds the sequencer; one byte waits in the output register.
`include "dns_query_builder_macros.svh"

module dns_query_builder #(
    parameter int MAX_LABEL = dqb_pkg::MAX_LABEL_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // name_char [7:0], query_id [23:8]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte [7:0]
    output logic        m_tlast,
    output logic        m_tuser    // label_overflow [0]
);

    dqb_pkg::cmd_t    cmd;
    dqb_pkg::status_t status;

    dqb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dqb_datapath #(
        .MAX_LABEL (MAX_LABEL)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    `DQB_ASSERT_SAME(a_emit_slot_free, aclk, aresetn, cmd.emit, status.out_free)
    `DQB_ASSERT_SAME(a_last_is_class, aclk, aresetn, m_tvalid && m_tlast, m_tdata == dqb_pkg::BYTE_ONE)
    `DQB_ASSERT_NEXT(a_header_starts, aclk, aresetn, cmd.accept && !status.in_message, cmd.emit || !status.out_free)

endmodule

>>> hw/rtl/dqb_ctrl.sv
module dqb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  dqb_pkg::status_t status,
    output dqb_pkg::cmd_t    cmd
);

    dqb_pkg::state_t state_reg;
    dqb_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dqb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready = 1'b0;
        cmd = '0;
        cmd.sel = dqb_pkg::SEL_HEADER;
        unique case (state_reg)
            dqb_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (!status.in_message) begin
                        state_next = dqb_pkg::ST_HEADER;
                    end else if (status.in_dot || status.in_last) begin
                        state_next = dqb_pkg::ST_LEN;
                    end
                end
            end
            dqb_pkg::ST_HEADER: begin
                cmd.sel = dqb_pkg::SEL_HEADER;
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.seq == dqb_pkg::HDR_LAST) begin
                        cmd.seq_clr = 1'b1;
                        state_next = (status.held_dot || status.held_last) ?
                                     dqb_pkg::ST_LEN : dqb_pkg::ST_IDLE;
                    end else begin
                        cmd.seq_inc = 1'b1;
                    end
                end
            end
            dqb_pkg::ST_LEN: begin
                cmd.sel = dqb_pkg::SEL_LEN;
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.rd_start = 1'b1;
                    if (status.count_zero) begin
                        cmd.clear_count = 1'b1;
                        state_next = status.held_last ? dqb_pkg::ST_TAIL : dqb_pkg::ST_IDLE;
                    end else begin
                        state_next = dqb_pkg::ST_DATA;
                    end
                end
            end
            dqb_pkg::ST_DATA: begin
                cmd.sel = dqb_pkg::SEL_DATA;
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.rd_step = 1'b1;
                    if (status.rd_done) begin
                        cmd.clear_count = 1'b1;
                        state_next = status.held_last ? dqb_pkg::ST_TAIL : dqb_pkg::ST_IDLE;
                    end
                end
            end
            dqb_pkg::ST_TAIL: begin
                cmd.sel = dqb_pkg::SEL_TAIL;
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.seq == dqb_pkg::TAIL_LAST) begin
                        cmd.out_last = 1'b1;
                        cmd.seq_clr = 1'b1;
                        state_next = dqb_pkg::ST_IDLE;
                    end else begin
                        cmd.seq_inc = 1'b1;
                    end
                end
            end
            default: begin
                state_next = dqb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/dqb_datapath.sv
module dqb_datapath #(
    parameter int MAX_LABEL = dqb_pkg::MAX_LABEL_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [23:0]      s_tdata,
    input  logic             s_tlast,
    input  dqb_pkg::cmd_t    cmd,
    output dqb_pkg::status_t status,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    localparam int CNT_W = $clog2(MAX_LABEL + 1);
    localparam int ADDR_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LABEL);

    logic [7:0] label_mem [MAX_LABEL];

    logic                     in_message_reg, in_message_next;
    logic                     ovf_reg, ovf_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         rd_idx_reg, rd_idx_next;
    logic [dqb_pkg::SEQ_W-1:0] seq_reg, seq_next;
    logic                     dot_reg, last_reg;
    logic [15:0]              id_reg;
    logic [7:0]               rd_data_reg;
    logic                     m_valid_reg, m_valid_next;
    logic [7:0]               m_byte_reg;
    logic                     m_last_reg;
    logic                     m_ovf_reg;

    logic [7:0]       in_char;
    logic             in_dot;
    logic [CNT_W-1:0] count_eff;
    logic             store_char;
    logic [7:0]       hdr_byte;
    logic [7:0]       tail_byte;
    logic [7:0]       out_byte;

    assign in_char = s_tdata[7:0];
    assign in_dot = (in_char == dqb_pkg::DOT_CHAR);
    assign count_eff = in_message_reg ? count_reg : '0;
    assign store_char = cmd.accept && !in_dot && (count_eff < CNT_MAX);

    always_comb begin
        in_message_next = in_message_reg;
        ovf_next = ovf_reg;
        count_next = count_reg;
        if (cmd.accept) begin
            in_message_next = !s_tlast;
            ovf_next = (in_message_reg ? ovf_reg : 1'b0) |
                       (!in_dot && (count_eff >= CNT_MAX));
            count_next = store_char ? count_eff + CNT_W'(1) : count_eff;
        end else if (cmd.clear_count) begin
            count_next = '0;
        end
    end

    always_comb begin
        seq_next = seq_reg;
        if (cmd.accept || cmd.seq_clr) begin
            seq_next = '0;
        end else if (cmd.seq_inc) begin
            seq_next = seq_reg + dqb_pkg::SEQ_W'(1);
        end
    end

    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_start) begin
            rd_idx_next = CNT_W'(1);
        end else if (cmd.rd_step) begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_message_reg <= 1'b0;
            ovf_reg <= 1'b0;
            count_reg <= '0;
            seq_reg <= '0;
            rd_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            in_message_reg <= in_message_next;
            ovf_reg <= ovf_next;
            count_reg <= count_next;
            seq_reg <= seq_next;
            rd_idx_reg <= rd_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            dot_reg <= in_dot;
            last_reg <= s_tlast;
            if (!in_message_reg) begin
                id_reg <= s_tdata[23:8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (store_char) begin
            label_mem[count_eff[ADDR_W-1:0]] <= in_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_start) begin
            rd_data_reg <= label_mem[0];
        end else if (cmd.rd_step && (rd_idx_reg < CNT_MAX)) begin
            rd_data_reg <= label_mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    always_comb begin
        case (seq_reg)
            dqb_pkg::HDR_ID_HI:      hdr_byte = id_reg[15:8];
            dqb_pkg::HDR_ID_LO:      hdr_byte = id_reg[7:0];
            dqb_pkg::HDR_FLAGS_HI:   hdr_byte = dqb_pkg::BYTE_ONE;
            dqb_pkg::HDR_QDCOUNT_LO: hdr_byte = dqb_pkg::BYTE_ONE;
            default:                 hdr_byte = dqb_pkg::BYTE_ZERO;
        endcase
    end

    always_comb begin
        case (seq_reg) inside
            dqb_pkg::TAIL_TYPE_LO, dqb_pkg::TAIL_LAST: tail_byte = dqb_pkg::BYTE_ONE;
            default:                                   tail_byte = dqb_pkg::BYTE_ZERO;
        endcase
    end

    always_comb begin
        unique case (cmd.sel)
            dqb_pkg::SEL_HEADER: out_byte = hdr_byte;
            dqb_pkg::SEL_LEN:    out_byte = 8'(count_reg);
            dqb_pkg::SEL_DATA:   out_byte = rd_data_reg;
            dqb_pkg::SEL_TAIL:   out_byte = tail_byte;
            default:             out_byte = dqb_pkg::BYTE_ZERO;
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_byte_reg <= out_byte;
            m_last_reg <= cmd.out_last;
            m_ovf_reg <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_byte_reg;
    assign m_tlast = m_last_reg;
    assign m_tuser = m_ovf_reg;

    assign status.in_message = in_message_reg;
    assign status.in_dot = in_dot;
    assign status.in_last = s_tlast;
    assign status.held_dot = dot_reg;
    assign status.held_last = last_reg;
    assign status.count_zero = (count_reg == '0);
    assign status.rd_done = (rd_idx_reg == count_reg);
    assign status.out_free = !m_valid_reg || m_tready;
    assign status.seq = seq_reg;

endmodule
